// ----- hw/rtl/fwksr_pkg.sv -----
// ----------------------------------------------------------------------------
// Four-way key ramp package
// Shared types, register indexes and a helper function for the key ramp block.
// ----------------------------------------------------------------------------
package fwksr_pkg;

  // Default number of fraction bits of the held ratios.
  localparam int unsigned FRAC_BITS = 14;

  localparam int unsigned DIR_COUNT = 4;
  localparam int unsigned COUNT_W   = 8;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;

  // Direction indexes.
  localparam logic [1:0] DIR_FWD   = 2'd0;
  localparam logic [1:0] DIR_BACK  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  // Configuration register indexes and widths.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 10;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_UP       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_DOWN     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UPDATE_PERIOD = 2'd2;

  localparam logic [6:0] STEP_UP_RST       = 7'd10;
  localparam logic [7:0] STEP_DOWN_RST     = 8'd100;
  localparam logic [9:0] UPDATE_PERIOD_RST = 10'd10;

  typedef struct packed {
    logic        key_forward;
    logic        key_backward;
    logic        key_left;
    logic        key_right;
    logic [31:0] now;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] vx;
    logic signed [15:0] vy;
  } out_item_t;

  // Status of the shared square root unit.
  typedef struct packed {
    logic busy;
    logic done;
  } sqrt_stat_t;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_SQRT = 5'b00100,
    S_OUT  = 5'b01000,
    S_HOLD = 5'b10000
  } state_e;

  // Clamp a signed difference to the signed 16-bit range.
  function automatic logic signed [15:0] sat16(logic signed [31:0] v);
    logic signed [15:0] r;
    if (v > 32'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -32'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/fwksr_isqrt.sv -----
// ----------------------------------------------------------------------------
// Iterative integer square root
// Digit-by-digit root, one result bit per cycle, shared by all directions.
// ----------------------------------------------------------------------------
module fwksr_isqrt
  import fwksr_pkg::*;
#(
  parameter int unsigned RootW = FRAC_BITS + 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [2*RootW-1:0]   radicand_i,
  output logic [RootW-1:0]     root_o,
  output sqrt_stat_t           stat_o
);

  localparam int unsigned CntW = (RootW > 1) ? $clog2(RootW) : 1;

  logic            busy_q;
  logic            done_q;
  logic [CntW-1:0] cnt_q;
  logic [2*RootW-1:0] rad_q;
  logic [RootW:0]     rem_q;
  logic [RootW-1:0]   root_q;

  logic [RootW+2:0] rem_sh;
  logic [RootW+2:0] trial;
  logic             ge;
  logic [RootW+2:0] rem_nx;

  always_comb begin
    rem_sh = {rem_q, rad_q[2*RootW-1 -: 2]};
    trial  = {1'b0, root_q, 2'b01};
    ge     = (rem_sh >= trial);
    rem_nx = ge ? (rem_sh - trial) : rem_sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(RootW - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[2*RootW-3:0], 2'b00};
      rem_q  <= rem_nx[RootW:0];
      root_q <= {root_q[RootW-2:0], ge};
    end
  end

  assign root_o      = root_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

// ----- hw/rtl/four_way_key_sqrt_ramp.sv -----
// ----------------------------------------------------------------------------
// Four-way key ramp
// Ramps four direction press counts and reports signed ratio differences.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake              | Payload
//  --------+-----------+------------------------+--------------------------
//  in      | input     | in_valid_i / in_stall_o   | in_item_i (keys, now)
//  out     | output    | out_valid_o / out_stall_i | out_item_o (vx, vy)
//  cfg     | input     | cfg_we_i                  | cfg_idx_i, cfg_wdata_i
//
// An item without a ramp update goes from the idle state straight to the output
// state. An item that updates runs a multiply and a root state for each direction
// in turn on the shared square root unit, which yields one root bit per cycle.
// Reset is asynchronous and active low; no clearing pass is needed.
// A finished result waits in the output register while the next item is
// taken; the block only stalls at the end of an item if that register is full.
// ----------------------------------------------------------------------------
module four_way_key_sqrt_ramp
  import fwksr_pkg::*;
#(
  parameter int unsigned FracBits = FRAC_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_item_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned RatioW = FracBits + 1;
  localparam int unsigned ProdW  = 2 * RatioW;
  localparam int unsigned ScaleW = 2 * FracBits - 6;
  localparam logic [63:0] ScaleNum  = (64'd1 << (2 * FracBits)) * 64'd8 + 64'd500;
  localparam logic [63:0] ScaleWide = ScaleNum / 64'd1000;
  localparam logic [ScaleW-1:0] RatioScale = ScaleW'(ScaleWide);

  state_e state_q, state_d;

  logic [6:0] step_up_q;
  logic [7:0] step_down_q;
  logic [9:0] period_q;

  logic [COUNT_W-1:0] count_q [DIR_COUNT];
  logic [RatioW-1:0]  ratio_q [DIR_COUNT];
  logic [31:0]        next_update_q;
  logic [3:0]         key_q;
  logic [1:0]         dir_q;

  out_item_t out_q;
  logic      out_valid_q;

  logic               sq_start;
  logic [ProdW-1:0]   prod;
  logic [RatioW-1:0]  root;
  sqrt_stat_t         sq_stat;

  logic               accept;
  logic               due;
  logic [COUNT_W-1:0] cnt_cur;
  logic [COUNT_W:0]   up_sum;
  logic [COUNT_W-1:0] cnt_up;
  logic [COUNT_W-1:0] cnt_down;
  logic [COUNT_W-1:0] cnt_new;
  logic               out_free;
  out_item_t          res;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_up_q   <= STEP_UP_RST;
      step_down_q <= STEP_DOWN_RST;
      period_q    <= UPDATE_PERIOD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_STEP_UP:       step_up_q   <= cfg_wdata_i[6:0];
        CFG_STEP_DOWN:     step_down_q <= cfg_wdata_i[7:0];
        CFG_UPDATE_PERIOD: period_q    <= cfg_wdata_i[9:0];
        default: ;
      endcase
    end
  end

  assign accept   = (state_q == S_IDLE) && in_valid_i;
  assign due      = (in_item_i.now >= next_update_q);
  assign out_free = !out_valid_q || !out_stall_i;

  // Radicand for the current direction; registered inside the root unit.
  assign cnt_cur  = count_q[dir_q];
  assign prod     = ProdW'(cnt_cur) * ProdW'(RatioScale);
  assign sq_start = (state_q == S_MUL);

  fwksr_isqrt #(
    .RootW (RatioW)
  ) u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sq_start),
    .radicand_i (prod),
    .root_o     (root),
    .stat_o     (sq_stat)
  );

  // Count ramp: up while held and the ratio is below one, down after release.
  always_comb begin
    up_sum   = {1'b0, cnt_cur} + (COUNT_W+1)'(step_up_q);
    cnt_up   = up_sum[COUNT_W] ? COUNT_MAX : up_sum[COUNT_W-1:0];
    cnt_down = (cnt_cur > step_down_q) ? (cnt_cur - step_down_q) : '0;
    if (key_q[dir_q]) begin
      cnt_new = root[RatioW-1] ? cnt_cur : cnt_up;
    end else begin
      cnt_new = cnt_down;
    end
  end

  always_comb begin
    res.vx = sat16(32'(signed'({1'b0, ratio_q[DIR_FWD]}))
                   - 32'(signed'({1'b0, ratio_q[DIR_BACK]})));
    res.vy = sat16(32'(signed'({1'b0, ratio_q[DIR_LEFT]}))
                   - 32'(signed'({1'b0, ratio_q[DIR_RIGHT]})));
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (accept) state_d = due ? S_MUL : S_OUT;
      S_MUL:  state_d = S_SQRT;
      S_SQRT: if (sq_stat.done) state_d = (dir_q == DIR_RIGHT) ? S_OUT : S_MUL;
      S_OUT:  state_d = out_free ? S_IDLE : S_HOLD;
      S_HOLD: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      next_update_q <= '0;
      dir_q         <= '0;
      key_q         <= '0;
      for (int i = 0; i < DIR_COUNT; i++) begin
        count_q[i] <= '0;
        ratio_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (accept) begin
        key_q <= {in_item_i.key_right, in_item_i.key_left,
                  in_item_i.key_backward, in_item_i.key_forward};
        dir_q <= DIR_FWD;
        // A pressed key clears the opposite direction first.
        if (in_item_i.key_forward)  count_q[DIR_BACK]  <= '0;
        if (in_item_i.key_backward) count_q[DIR_FWD]   <= '0;
        if (in_item_i.key_left)     count_q[DIR_RIGHT] <= '0;
        if (in_item_i.key_right)    count_q[DIR_LEFT]  <= '0;
        if (due) begin
          next_update_q <= in_item_i.now + 32'(period_q);
        end
      end
      if ((state_q == S_SQRT) && sq_stat.done) begin
        ratio_q[dir_q] <= root;
        count_q[dir_q] <= cnt_new;
        dir_q          <= dir_q + 1'b1;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (((state_q == S_OUT) || (state_q == S_HOLD)) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (((state_q == S_OUT) || (state_q == S_HOLD)) && out_free) begin
      out_q <= res;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // The root unit reports completion only while the sequencer waits for it.
  a_done_in_sqrt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_stat.done |-> (state_q == S_SQRT))
    else $error("square root finished outside the root state");

  // The root unit is never running while the block waits for an item.
  a_idle_unit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !sq_stat.busy)
    else $error("square root unit busy while idle");

  // A new result appears only at the end of an item.
  a_result_from_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q == S_OUT) || $past(state_q == S_HOLD)))
    else $error("result raised outside the end of an item");

endmodule
